>>> rtl/jfns_pkg.sv
// Shared constants for the Jacobi five-point stencil block.
// No dependencies; the rtl/ files other than jfns_ram refer to it by scoped names.
`timescale 1ns / 1ps

package jfns_pkg;

    // Default values for the top-level parameters.
    localparam int MAX_WIDTH_DEFAULT = 4096;
    localparam int CELL_BITS_DEFAULT = 32;

    // Fixed field and register widths.
    localparam int ROW_BITS        = 16;
    localparam int WIDTH_REG_BITS  = 13;
    localparam int HEIGHT_REG_BITS = 16;
    localparam int CFG_DATA_BITS   = 16;
    localparam int CFG_IDX_BITS    = 1;

    // Register indexes on the configuration port.
    localparam logic [CFG_IDX_BITS-1:0] REG_GRID_WIDTH  = 1'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_GRID_HEIGHT = 1'd1;

    // Register reset values.
    localparam logic [WIDTH_REG_BITS-1:0]  GRID_WIDTH_RESET  = 13'd4096;
    localparam logic [HEIGHT_REG_BITS-1:0] GRID_HEIGHT_RESET = 16'd3;

    // Queue between the front and back parts. Depth is a power of two so the
    // pointers wrap naturally.
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);
    localparam int QLVL_BITS   = $clog2(QUEUE_DEPTH + 1);

endpackage

>>> rtl/jfns_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// No dependencies. Read during write to the same address returns the old data.
`timescale 1ns / 1ps

module jfns_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> rtl/jfns_front.sv
// Front part of the stencil: configuration registers, raster position counters,
// line stores and the window stage. Depends on jfns_pkg and jfns_ram.
`timescale 1ns / 1ps

module jfns_front #(
    parameter int MAX_WIDTH = jfns_pkg::MAX_WIDTH_DEFAULT,
    parameter int CELL_BITS = jfns_pkg::CELL_BITS_DEFAULT,
    parameter int COL_BITS  = $clog2(MAX_WIDTH),
    parameter int ITEM_BITS = 4 * CELL_BITS + jfns_pkg::ROW_BITS + COL_BITS + 1
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [jfns_pkg::CFG_IDX_BITS-1:0] i_cfg_idx,
    input  logic [jfns_pkg::CFG_DATA_BITS-1:0] i_cfg_data,
    input  logic                              i_push,
    output logic                              o_full,
    input  logic [CELL_BITS-1:0]              i_cell_value,
    input  logic [jfns_pkg::QLVL_BITS-1:0]    i_q_level,
    output logic                              o_q_push,
    output logic [ITEM_BITS-1:0]              o_q_item
);

    localparam int RB = jfns_pkg::ROW_BITS;
    localparam int WB_MIN = jfns_pkg::WIDTH_REG_BITS;
    localparam int WB = ($clog2(MAX_WIDTH + 1) > WB_MIN) ? $clog2(MAX_WIDTH + 1) : WB_MIN;
    localparam int LB = jfns_pkg::QLVL_BITS;

    logic [jfns_pkg::WIDTH_REG_BITS-1:0]  r_grid_width;
    logic [jfns_pkg::HEIGHT_REG_BITS-1:0] r_grid_height;
    logic [COL_BITS-1:0]                  r_col;
    logic [RB-1:0]                        r_row;

    logic                 r_s1_valid;
    logic                 r_s1_int;
    logic                 r_s1_last;
    logic [RB-1:0]        r_s1_row;
    logic [COL_BITS-1:0]  r_s1_col;
    logic [CELL_BITS-1:0] r_s1_down;
    logic [CELL_BITS-1:0] r_left;

    logic [WB-1:0]        w_raw, w_eff, w_last, w_m2, c_ext;
    logic [RB-1:0]        h_eff, h_last;
    logic                 accept, interior, last_cell;
    logic [CELL_BITS-1:0] up_rd, centre_rd, right_rd;
    logic [LB:0]          level_sum;

    // Configuration writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grid_width  <= jfns_pkg::GRID_WIDTH_RESET;
            r_grid_height <= jfns_pkg::GRID_HEIGHT_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                jfns_pkg::REG_GRID_WIDTH: begin
                    r_grid_width <= i_cfg_data[jfns_pkg::WIDTH_REG_BITS-1:0];
                end
                jfns_pkg::REG_GRID_HEIGHT: begin
                    r_grid_height <= i_cfg_data[jfns_pkg::HEIGHT_REG_BITS-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // Effective grid geometry, clamped to the supported range.
    always_comb begin
        w_raw = WB'(r_grid_width);
        if (w_raw < WB'(3)) begin
            w_eff = WB'(3);
        end else if (w_raw > WB'(MAX_WIDTH)) begin
            w_eff = WB'(MAX_WIDTH);
        end else begin
            w_eff = w_raw;
        end
        w_last = w_eff - WB'(1);
        w_m2   = w_eff - WB'(2);
        h_eff  = (r_grid_height < RB'(3)) ? RB'(3) : r_grid_height;
        h_last = h_eff - RB'(1);
        c_ext  = WB'(r_col);
    end

    assign level_sum = (LB + 1)'(i_q_level) + (LB + 1)'(r_s1_valid & r_s1_int);
    assign o_full    = (level_sum >= (LB + 1)'(jfns_pkg::QUEUE_DEPTH));
    assign accept    = i_push & ~o_full;

    assign interior  = (r_row >= RB'(2)) && (r_row <= h_last) &&
                       (r_col != '0) && (c_ext <= w_m2);
    assign last_cell = (r_row == h_last) && (c_ext == w_m2);

    // Raster position of the next cell.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else if (accept) begin
            if (c_ext >= w_last) begin
                r_col <= '0;
                r_row <= (r_row >= h_last) ? '0 : r_row + RB'(1);
            end else begin
                r_col <= r_col + COL_BITS'(1);
            end
        end
    end

    // Two copies of the previous-row store give the centre and right reads
    // together. The older-row store is written in the cycle after, once the
    // centre value it takes over has come out of the previous-row store.
    jfns_ram #(.WIDTH(CELL_BITS), .DEPTH(MAX_WIDTH)) u_prev_centre (
        .i_clk   (i_clk),
        .i_we    (accept),
        .i_waddr (r_col),
        .i_wdata (i_cell_value),
        .i_raddr (r_col),
        .o_rdata (centre_rd)
    );

    jfns_ram #(.WIDTH(CELL_BITS), .DEPTH(MAX_WIDTH)) u_prev_right (
        .i_clk   (i_clk),
        .i_we    (accept),
        .i_waddr (r_col),
        .i_wdata (i_cell_value),
        .i_raddr (r_col + COL_BITS'(1)),
        .o_rdata (right_rd)
    );

    jfns_ram #(.WIDTH(CELL_BITS), .DEPTH(MAX_WIDTH)) u_older (
        .i_clk   (i_clk),
        .i_we    (r_s1_valid),
        .i_waddr (r_s1_col),
        .i_wdata (centre_rd),
        .i_raddr (r_col),
        .o_rdata (up_rd)
    );

    // Window stage: holds the accepted cell while the store reads complete.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s1_int   <= 1'b0;
            r_left     <= '0;
        end else begin
            r_s1_valid <= accept;
            r_s1_int   <= accept & interior;
            if (r_s1_valid) begin
                r_left <= centre_rd;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_last <= last_cell;
            r_s1_row  <= r_row - RB'(1);
            r_s1_col  <= r_col;
            r_s1_down <= i_cell_value;
        end
    end

    assign o_q_push = r_s1_valid & r_s1_int;
    assign o_q_item = {r_s1_last, r_s1_row, r_s1_col, right_rd, r_left, up_rd, r_s1_down};

endmodule

>>> rtl/jfns_back.sv
// Back part of the stencil: the item queue, the quarter-sum adder and the
// result register. Depends on jfns_pkg.
`timescale 1ns / 1ps

module jfns_back #(
    parameter int MAX_WIDTH = jfns_pkg::MAX_WIDTH_DEFAULT,
    parameter int CELL_BITS = jfns_pkg::CELL_BITS_DEFAULT,
    parameter int COL_BITS  = $clog2(MAX_WIDTH),
    parameter int ITEM_BITS = 4 * CELL_BITS + jfns_pkg::ROW_BITS + COL_BITS + 1
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_q_push,
    input  logic [ITEM_BITS-1:0]           i_q_item,
    output logic [jfns_pkg::QLVL_BITS-1:0] o_q_level,
    output logic                           o_empty,
    input  logic                           i_pop,
    output logic [CELL_BITS-1:0]           o_new_value,
    output logic [jfns_pkg::ROW_BITS-1:0]  o_center_row,
    output logic [COL_BITS-1:0]            o_center_col,
    output logic                           o_last_of_grid
);

    localparam int RB = jfns_pkg::ROW_BITS;
    localparam int PB = jfns_pkg::QPTR_BITS;
    localparam int LB = jfns_pkg::QLVL_BITS;
    localparam int SB = CELL_BITS + 2;

    logic [ITEM_BITS-1:0] r_mem [jfns_pkg::QUEUE_DEPTH];
    logic [PB-1:0]        r_wr_ptr, r_rd_ptr;
    logic [LB-1:0]        r_count;

    logic                 r_out_valid;
    logic [CELL_BITS-1:0] r_out_value;
    logic [RB-1:0]        r_out_row;
    logic [COL_BITS-1:0]  r_out_col;
    logic                 r_out_last;

    logic [ITEM_BITS-1:0] head;
    logic                 q_pop;
    logic [CELL_BITS-1:0] down_v, up_v, left_v, right_v;
    logic [COL_BITS-1:0]  col_v;
    logic [RB-1:0]        row_v;
    logic                 last_v;
    logic [SB-1:0]        sum;

    assign head  = r_mem[r_rd_ptr];
    assign q_pop = (r_count != '0) && (!r_out_valid || i_pop);

    assign {last_v, row_v, col_v, right_v, left_v, up_v, down_v} = head;

    // Floor of the sum over four: sign-extended sum, then drop two bits.
    assign sum = SB'(signed'(down_v)) + SB'(signed'(up_v)) +
                 SB'(signed'(left_v)) + SB'(signed'(right_v));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_q_push) begin
                r_wr_ptr <= r_wr_ptr + PB'(1);
            end
            if (q_pop) begin
                r_rd_ptr <= r_rd_ptr + PB'(1);
            end
            case ({i_q_push, q_pop})
                2'b10:   r_count <= r_count + LB'(1);
                2'b01:   r_count <= r_count - LB'(1);
                default: r_count <= r_count;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_q_push) begin
            r_mem[r_wr_ptr] <= i_q_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (q_pop) begin
            r_out_valid <= 1'b1;
        end else if (i_pop) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (q_pop) begin
            r_out_value <= sum[SB-1:2];
            r_out_row   <= row_v;
            r_out_col   <= col_v;
            r_out_last  <= last_v;
        end
    end

    assign o_q_level      = r_count;
    assign o_empty        = ~r_out_valid;
    assign o_new_value    = r_out_value;
    assign o_center_row   = r_out_row;
    assign o_center_col   = r_out_col;
    assign o_last_of_grid = r_out_last;

endmodule

>>> rtl/jacobi_four_neighbour_stencil.sv
// Top level of the streaming Jacobi five-point stencil.
// Depends on jfns_pkg, jfns_ram, jfns_front and jfns_back.
`timescale 1ns / 1ps

// Source cells enter through push/full in raster order, one transfer per clock cycle
// sustained while full is low, and for every interior cell the block delivers the
// floor of the sum of its four neighbours divided by four, in signed fixed point,
// through empty/pop. The result for centre (r-1, c) is produced by the transfer of
// cell (r, c); border cells produce nothing. An interior cell first passes the
// registered line store reads, at the end of which its item is written into the
// four-entry queue; the item then waits there until the output register is free
// or popped, and passes the adder into the output register. Full rises only
// when that queue, plus the cell in the read stage, can take no more, so the
// input keeps moving while a finished result waits to be popped. Write
// grid_width (index 0) and grid_height (index 1) only while the block is idle;
// a width outside 3..MAX_WIDTH and a height below 3 are clamped. The line
// stores are not cleared after reset: the first two rows of every grid fill
// them before any result reads them.
module jacobi_four_neighbour_stencil #(
    parameter int MAX_WIDTH = jfns_pkg::MAX_WIDTH_DEFAULT,
    parameter int CELL_BITS = jfns_pkg::CELL_BITS_DEFAULT
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [jfns_pkg::CFG_IDX_BITS-1:0]  i_cfg_idx,
    input  logic [jfns_pkg::CFG_DATA_BITS-1:0] i_cfg_data,
    input  logic                               push,
    output logic                               full,
    input  logic [CELL_BITS-1:0]               i_cell_value,
    output logic                               empty,
    input  logic                               pop,
    output logic [CELL_BITS-1:0]               o_new_value,
    output logic [jfns_pkg::ROW_BITS-1:0]      o_center_row,
    output logic [$clog2(MAX_WIDTH)-1:0]       o_center_col,
    output logic                               o_last_of_grid
);

    localparam int COL_BITS  = $clog2(MAX_WIDTH);
    localparam int ITEM_BITS = 4 * CELL_BITS + jfns_pkg::ROW_BITS + COL_BITS + 1;

    // Front to back: one queue entry per interior cell, carrying the four
    // neighbours and the centre position; the back reports its queue level.
    logic                           q_push;
    logic [ITEM_BITS-1:0]           q_item;
    logic [jfns_pkg::QLVL_BITS-1:0] q_level;

    jfns_front #(
        .MAX_WIDTH (MAX_WIDTH),
        .CELL_BITS (CELL_BITS),
        .COL_BITS  (COL_BITS),
        .ITEM_BITS (ITEM_BITS)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data),
        .i_push       (push),
        .o_full       (full),
        .i_cell_value (i_cell_value),
        .i_q_level    (q_level),
        .o_q_push     (q_push),
        .o_q_item     (q_item)
    );

    jfns_back #(
        .MAX_WIDTH (MAX_WIDTH),
        .CELL_BITS (CELL_BITS),
        .COL_BITS  (COL_BITS),
        .ITEM_BITS (ITEM_BITS)
    ) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_q_push       (q_push),
        .i_q_item       (q_item),
        .o_q_level      (q_level),
        .o_empty        (empty),
        .i_pop          (pop),
        .o_new_value    (o_new_value),
        .o_center_row   (o_center_row),
        .o_center_col   (o_center_col),
        .o_last_of_grid (o_last_of_grid)
    );

    // The full calculation must leave room for every cell in the read stage.
    a_queue_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_push |-> (q_level < jfns_pkg::QPTR_BITS'(0) + jfns_pkg::QLVL_BITS'(jfns_pkg::QUEUE_DEPTH)))
        else $error("queue entry pushed with no room");

    a_level_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_level <= jfns_pkg::QLVL_BITS'(jfns_pkg::QUEUE_DEPTH))
        else $error("queue level beyond depth");

    // Only interior cells reach the output, so neither coordinate is zero.
    a_interior_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty |-> (o_center_row != '0) && (o_center_col != '0))
        else $error("border position on the result port");

    // A result needs an interior cell in the queue in the cycle before.
    a_result_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(empty) |-> $past(q_level) != '0)
        else $error("result delivered with an empty queue");

endmodule

>>> tb/jacobi_four_neighbour_stencil_test.sv
// Self-checking testbench for the streaming Jacobi five-point stencil block.
// Depends on jfns_pkg and jacobi_four_neighbour_stencil from rtl/; it needs no other file.
`timescale 1ns / 1ps

// The testbench streams grid cells into the block through its push/full side.
// A predictor in this file keeps its own copy of the two line stores, the
// left-neighbour cell, the row and column position and the two geometry
// registers. For every accepted transfer it works out whether an interior
// cell is finished and, if so, queues the expected update. A separate process
// pops results at a random pace and compares every field with the oldest
// queued update.
module jacobi_four_neighbour_stencil_test;

    localparam int CELL_W       = jfns_pkg::CELL_BITS_DEFAULT;
    localparam int LINE_LEN     = jfns_pkg::MAX_WIDTH_DEFAULT;
    localparam int COL_BITS     = $clog2(LINE_LEN);
    localparam int ROW_BITS     = jfns_pkg::ROW_BITS;
    localparam int CFG_W        = jfns_pkg::CFG_DATA_BITS;
    localparam int CFG_IDX_W    = jfns_pkg::CFG_IDX_BITS;

    // The settling pause before a register write gives the pipeline a good
    // margin to retire the last transfers.
    localparam int SETTLE_CYCLES = 8;
    localparam int RANDOM_CELLS  = 1600;
    // Length of the first row sent at a very wide geometry before the width
    // is cut down to it. It also bounds the line store entries that later
    // tests may read, so it stays above the widest random grid.
    localparam int PROBE_COLS    = 48;
    // About two thousand cells at the slowest pace of both sides, with the
    // long receiver holds, stay several times below this.
    localparam longint RUN_LIMIT_NS = 64'd5_000_000;

    typedef struct packed {
        logic [CELL_W-1:0]   new_value;
        logic [ROW_BITS-1:0] center_row;
        logic [COL_BITS-1:0] center_col;
        logic                last_of_grid;
    } stencil_update_t;

    logic                 i_clk          = 1'b0;
    logic                 i_rst_n        = 1'b0;
    logic                 i_cfg_we       = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_idx      = jfns_pkg::REG_GRID_WIDTH;
    logic [CFG_W-1:0]     i_cfg_data     = '0;
    logic                 push           = 1'b0;
    logic                 full;
    logic [CELL_W-1:0]    i_cell_value   = '0;
    logic                 empty;
    logic                 pop            = 1'b0;
    logic [CELL_W-1:0]    o_new_value;
    logic [ROW_BITS-1:0]  o_center_row;
    logic [COL_BITS-1:0]  o_center_col;
    logic                 o_last_of_grid;

    jacobi_four_neighbour_stencil uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_data     (i_cfg_data),
        .push           (push),
        .full           (full),
        .i_cell_value   (i_cell_value),
        .empty          (empty),
        .pop            (pop),
        .o_new_value    (o_new_value),
        .o_center_row   (o_center_row),
        .o_center_col   (o_center_col),
        .o_last_of_grid (o_last_of_grid)
    );

    always #4 i_clk = ~i_clk;

    // Predictor state. The upper line holds the row two above the incoming
    // one and the middle line the row just above it; each entry moves up as
    // the incoming cell overwrites the middle line at the same column.
    logic [CELL_W-1:0]          upper_line  [LINE_LEN];
    logic [CELL_W-1:0]          middle_line [LINE_LEN];
    logic [CELL_W-1:0]          left_of_col;
    int unsigned                next_col;
    int unsigned                next_row;
    logic [jfns_pkg::WIDTH_REG_BITS-1:0]  grid_cols_reg = jfns_pkg::GRID_WIDTH_RESET;
    logic [jfns_pkg::HEIGHT_REG_BITS-1:0] grid_rows_reg = jfns_pkg::GRID_HEIGHT_RESET;

    stencil_update_t expected_updates [$];
    int unsigned     mismatch_count = 0;
    int unsigned     cells_sent     = 0;

    // Pacing knobs shared by the sender, the receiver and the tests.
    int unsigned send_gap_max = 15;
    int unsigned take_gap_max = 15;
    int unsigned hold_left    = 0;

    // Floor of the four-neighbour sum over four. The sum is formed two bits
    // wider so it cannot overflow; dropping its two low bits is the floor.
    function automatic logic [CELL_W-1:0] quarter_of_sum(
        logic signed [CELL_W-1:0] a, logic signed [CELL_W-1:0] b,
        logic signed [CELL_W-1:0] c, logic signed [CELL_W-1:0] d);
        logic signed [CELL_W+1:0] total;
        total = a + b + c + d;
        return total[CELL_W+1:2];
    endfunction

    // Advance the predictor by one accepted cell and queue the update that
    // the cell completes, if any.
    function automatic void advance_stencil(logic [CELL_W-1:0] cell_in);
        int unsigned       cols, rows;
        logic [CELL_W-1:0] above, centre, right;
        stencil_update_t   upd;
        cols = grid_cols_reg;
        rows = grid_rows_reg;
        if (cols < 3) cols = 3;
        if (cols > LINE_LEN) cols = LINE_LEN;
        if (rows < 3) rows = 3;

        above  = (next_col < LINE_LEN) ? upper_line[next_col] : '0;
        centre = (next_col < LINE_LEN) ? middle_line[next_col] : '0;
        right  = (next_col + 1 < LINE_LEN) ? middle_line[next_col + 1] : '0;

        // The incoming cell is the lower neighbour of the centre one row up.
        if (next_row >= 2 && next_row <= rows - 1 && next_col >= 1 && next_col <= cols - 2) begin
            upd.new_value    = quarter_of_sum(above, cell_in, left_of_col, right);
            upd.center_row   = ROW_BITS'(next_row - 1);
            upd.center_col   = COL_BITS'(next_col);
            upd.last_of_grid = (next_row - 1 == rows - 2) && (next_col == cols - 2);
            expected_updates.push_back(upd);
        end

        if (next_col < LINE_LEN) begin
            upper_line[next_col]  = centre;
            middle_line[next_col] = cell_in;
        end
        left_of_col = centre;

        // A counter at or past its last index wraps, which also covers a
        // geometry that shrank in the middle of a grid.
        if (next_col >= cols - 1) begin
            next_col = 0;
            next_row = (next_row >= rows - 1) ? 0 : ((next_row + 1) & 16'hFFFF);
        end else begin
            next_col = next_col + 1;
        end
    endfunction

    // Mostly random words, with the extremes and values near zero mixed in
    // often so that sums land on both sides of every rounding boundary.
    function automatic logic [CELL_W-1:0] pick_cell_value();
        case ($urandom_range(0, 9))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return 32'hFFFF_FFFF;
            3: return 32'h0000_0000;
            4: return $urandom_range(0, 511) - 32'd256;
            default: return $urandom();
        endcase
    endfunction

    function automatic int unsigned pick_gap_limit();
        case ($urandom_range(0, 3))
            0: return 0;
            1: return 3;
            default: return 15;
        endcase
    endfunction

    // One input transfer. Push stays high after the transfer, so that a
    // following cell with no gap goes out on the very next cycle.
    task automatic push_cell(input logic [CELL_W-1:0] value);
        int unsigned gap;
        gap = $urandom_range(0, send_gap_max);
        if (gap > 0) begin
            push <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        push         <= 1'b1;
        i_cell_value <= value;
        do @(posedge i_clk); while (full);
        advance_stencil(value);
        cells_sent++;
    endtask

    task automatic feed_cells(input int unsigned count);
        repeat (count) push_cell(pick_cell_value());
    endtask

    // Send random cells until the predicted position is back at the start
    // of a grid.
    task automatic finish_grid();
        while (next_col != 0 || next_row != 0) push_cell(pick_cell_value());
    endtask

    // Stop offering cells and wait until every predicted update has been
    // popped, then give the pipeline time to retire cells that cause none.
    task automatic settle();
        push <= 1'b0;
        while (expected_updates.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_register(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        if (idx == jfns_pkg::REG_GRID_WIDTH) begin
            grid_cols_reg = data[jfns_pkg::WIDTH_REG_BITS-1:0];
        end else if (idx == jfns_pkg::REG_GRID_HEIGHT) begin
            grid_rows_reg = data[jfns_pkg::HEIGHT_REG_BITS-1:0];
        end
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic note_mismatch(input string field, input logic [CELL_W-1:0] want,
                                 input logic [CELL_W-1:0] got);
        mismatch_count++;
        $display("%0t: %s expected %h, actual %h", $time, field, want, got);
    endtask

    task automatic check_update();
        stencil_update_t want;
        if (expected_updates.size() == 0) begin
            note_mismatch("unexpected result, new_value", '0, o_new_value);
        end else begin
            want = expected_updates.pop_front();
            if (o_new_value !== want.new_value)
                note_mismatch("new_value", want.new_value, o_new_value);
            if (o_center_row !== want.center_row)
                note_mismatch("center_row", CELL_W'(want.center_row), CELL_W'(o_center_row));
            if (o_center_col !== want.center_col)
                note_mismatch("center_col", CELL_W'(want.center_col), CELL_W'(o_center_col));
            if (o_last_of_grid !== want.last_of_grid)
                note_mismatch("last_of_grid", CELL_W'(want.last_of_grid),
                              CELL_W'(o_last_of_grid));
        end
    endtask

    // Result side. After each transfer the receiver draws how many cycles to
    // leave pop low. A hold request from a test overrides that and keeps pop
    // low for a long stretch so the block backs up into its input.
    initial begin : take_results
        int unsigned take_wait;
        take_wait = 0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && pop && !empty) begin
                check_update();
                take_wait = $urandom_range(0, take_gap_max);
            end
            if (hold_left > 0) begin
                hold_left--;
                pop <= 1'b0;
            end else if (take_wait > 0) begin
                take_wait--;
                pop <= 1'b0;
            end else begin
                pop <= 1'b1;
            end
        end
    end

    // The geometry after reset is the widest grid with the fewest rows. No
    // register is written before this test, so it checks the reset values: a
    // short first row must neither wrap nor produce anything, and once the
    // width is cut down to that row's length the grid must end after two more
    // rows. Those rows leave the low line store entries written.
    task automatic test_reset_geometry();
        send_gap_max = 3;
        take_gap_max = 3;
        feed_cells(PROBE_COLS);
        settle();
        write_register(jfns_pkg::REG_GRID_WIDTH, CFG_W'(PROBE_COLS));
        finish_grid();
        settle();
    endtask

    // Three 3x3 grids, each with exactly one interior cell. The width is
    // written with only high bits set, which mask off to zero and clamp to
    // three; the height is written below three. The grids give the most
    // negative sum, the most positive sum and a small negative sum that must
    // round toward minus infinity.
    task automatic test_corner_values();
        logic [CELL_W-1:0] mixed [9];
        mixed = '{32'd5, -32'sd7, 32'd1, 32'd3, 32'd9, 32'd2, 32'd0, 32'd1, 32'd4};
        send_gap_max = 15;
        take_gap_max = 15;
        write_register(jfns_pkg::REG_GRID_WIDTH, 16'hE000);
        write_register(jfns_pkg::REG_GRID_HEIGHT, 16'h0001);
        repeat (9) push_cell(32'h8000_0000);
        repeat (9) push_cell(32'h7FFF_FFFF);
        foreach (mixed[i]) push_cell(mixed[i]);
        settle();
    endtask

    // All ones in the width register is far above the line length and must
    // act as the full line length, so a short first row neither wraps nor
    // produces anything before the width is cut down to its length.
    task automatic test_width_clamp_high();
        send_gap_max = 3;
        take_gap_max = 3;
        write_register(jfns_pkg::REG_GRID_WIDTH, 16'hFFFF);
        write_register(jfns_pkg::REG_GRID_HEIGHT, 16'd3);
        feed_cells(PROBE_COLS);
        settle();
        write_register(jfns_pkg::REG_GRID_WIDTH, CFG_W'(PROBE_COLS));
        finish_grid();
        settle();
    endtask

    // Geometry changes in the middle of a grid. First the tallest height is
    // cut down while the row counter is already past the new last row, so the
    // current row produces nothing and wraps to a new grid. Then the width is
    // cut down while the column counter is past the new last column, so the
    // row ends at once and the grid goes on at the new width.
    task automatic test_midgrid_rewrite();
        send_gap_max = 15;
        take_gap_max = 15;
        write_register(jfns_pkg::REG_GRID_WIDTH, 16'd4);
        write_register(jfns_pkg::REG_GRID_HEIGHT, 16'hFFFF);
        feed_cells(8 * 4);
        settle();
        write_register(jfns_pkg::REG_GRID_HEIGHT, 16'd3);
        finish_grid();
        feed_cells(3 * 4);
        settle();
        write_register(jfns_pkg::REG_GRID_WIDTH, 16'd8);
        write_register(jfns_pkg::REG_GRID_HEIGHT, 16'd5);
        feed_cells(2 * 8 + 5);
        settle();
        write_register(jfns_pkg::REG_GRID_WIDTH, 16'd4);
        finish_grid();
        settle();
    endtask

    // The receiver stops for a long stretch while cells keep coming with no
    // gap, so the internal queue fills and full must hold the sender back.
    // Afterwards the sender waits for every update before going on.
    task automatic test_output_stall();
        write_register(jfns_pkg::REG_GRID_WIDTH, 16'd5);
        write_register(jfns_pkg::REG_GRID_HEIGHT, 16'd12);
        send_gap_max = 0;
        take_gap_max = 0;
        hold_left    = 400;
        feed_cells(30);
        settle();
        send_gap_max = 15;
        take_gap_max = 15;
        finish_grid();
        settle();
    endtask

    // Mostly complete grids of small random geometry with random pacing,
    // including out-of-range register values and random high bits in the
    // width write. Now and then a grid is cut short, one register changes,
    // and the stream runs on to the next grid start.
    task automatic test_random_grids();
        int unsigned stop_at, cols, rows, cells, cut;
        stop_at = cells_sent + RANDOM_CELLS;
        while (cells_sent < stop_at) begin
            settle();
            case ($urandom_range(0, 9))
                0: cols = $urandom_range(0, 2);
                1: cols = $urandom_range(13, 40);
                default: cols = $urandom_range(3, 12);
            endcase
            rows = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 2) : $urandom_range(3, 8);
            write_register(jfns_pkg::REG_GRID_WIDTH,
                           {3'($urandom_range(0, 7)), 13'(cols)});
            write_register(jfns_pkg::REG_GRID_HEIGHT, 16'(rows));
            send_gap_max = pick_gap_limit();
            take_gap_max = pick_gap_limit();
            if ($urandom_range(0, 7) == 0) hold_left = $urandom_range(20, 120);
            if (cols < 3) cols = 3;
            if (rows < 3) rows = 3;
            cells = cols * rows;
            if ($urandom_range(0, 5) == 0) begin
                cut = $urandom_range(1, cells - 1);
                feed_cells(cut);
                settle();
                if ($urandom_range(0, 1) == 1) begin
                    write_register(jfns_pkg::REG_GRID_WIDTH, 16'($urandom_range(3, 12)));
                end else begin
                    write_register(jfns_pkg::REG_GRID_HEIGHT, 16'($urandom_range(3, 8)));
                end
                finish_grid();
            end else begin
                feed_cells(cells);
            end
        end
        settle();
    endtask

    initial begin : run_tests
        for (int i = 0; i < LINE_LEN; i++) begin
            upper_line[i]  = '0;
            middle_line[i] = '0;
        end
        left_of_col = '0;
        next_col    = 0;
        next_row    = 0;

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_geometry();
        test_corner_values();
        test_width_clamp_high();
        test_midgrid_rewrite();
        test_output_stall();
        test_random_grids();

        // Catch any stray result that arrives after the last expected one.
        repeat (2 * SETTLE_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0 && expected_updates.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

    initial begin : watchdog
        #(RUN_LIMIT_NS);
        $display("TB_ERROR");
        $finish;
    end

endmodule

>>> sim.f
rtl/jfns_pkg.sv
rtl/jfns_ram.sv
rtl/jfns_front.sv
rtl/jfns_back.sv
rtl/jacobi_four_neighbour_stencil.sv
tb/jacobi_four_neighbour_stencil_test.sv
